// ----- rtl/tcse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcse_pkg
// Types, codes and constants shared by the TCP connection state engine.
// ----------------------------------------------------------------------------
package tcse_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int IN_DATA_W     = 200;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 160;
    localparam logic [15:0] PORT_FIRST  = 16'd32768;
    localparam logic [15:0] WIN_RST_DEF = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_SEG     = 3'd0,
        OP_LISTEN  = 3'd1,
        OP_CONNECT = 3'd2,
        OP_CLOSE   = 3'd3,
        OP_ABORT   = 3'd4,
        OP_NONE    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        RC_OK      = 3'd0,
        RC_BADSUM  = 3'd1,
        RC_OOS     = 3'd2,
        RC_NOPORT  = 3'd3,
        RC_EXISTS  = 3'd4,
        RC_FULL    = 3'd5
    } t_rcode;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_SYN    = 3'd1,
        K_SYNACK = 3'd2,
        K_ACK    = 3'd3,
        K_FIN    = 3'd4,
        K_RST    = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLOSE      = 4'd0,
        ST_LISTEN     = 4'd1,
        ST_SYN_SENT   = 4'd2,
        ST_SYN_RECV   = 4'd3,
        ST_ESTAB      = 4'd4,
        ST_FW1        = 4'd5,
        ST_FW2        = 4'd6,
        ST_CLOSING    = 4'd7,
        ST_TIME_WAIT  = 4'd8,
        ST_CLOSE_WAIT = 4'd9
    } t_conn_state;

    typedef enum logic [2:0] {
        B_IDLE, B_LOOK, B_SEARCH, B_READ, B_EXEC
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] lport;
        logic [15:0] rport;
        logic [31:0] rip;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [3:0]  flags;
        logic [15:0] pwin;
        logic [15:0] len;
        logic        cksum_ok;
        logic [31:0] iss;
    } t_item;

    typedef struct packed {
        logic [15:0] peer_port;
        logic [31:0] peer_ip;
        logic [31:0] snd_una;
        logic [31:0] rcv_next;
        logic [15:0] snd_win;
        t_conn_state state;
    } t_record;

    typedef struct packed {
        logic [3:0]  state;
        logic [3:0]  slot;
        logic [15:0] win;
        logic [31:0] ip;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] ack;
        logic [31:0] seq;
        logic [2:0]  kind;
        logic [2:0]  code;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/tcse_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcse_front
// Accepts command items, decodes the command and registers the item.
// ----------------------------------------------------------------------------
module tcse_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [tcse_pkg::IN_DATA_W-1:0] i_data,
    input  wire logic [tcse_pkg::IN_USER_W-1:0] i_user,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output tcse_pkg::t_item                     o_item
);
    import tcse_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        case (i_user)
            OP_SEG:     n_item.op = OP_SEG;
            OP_LISTEN:  n_item.op = OP_LISTEN;
            OP_CONNECT: n_item.op = OP_CONNECT;
            OP_CLOSE:   n_item.op = OP_CLOSE;
            OP_ABORT:   n_item.op = OP_ABORT;
            default:    n_item.op = OP_NONE;
        endcase
        n_item.lport    = i_data[15:0];
        n_item.rport    = i_data[31:16];
        n_item.rip      = i_data[63:32];
        n_item.seq      = i_data[95:64];
        n_item.ack      = i_data[127:96];
        n_item.flags    = i_data[131:128];
        n_item.pwin     = i_data[147:132];
        n_item.len      = i_data[163:148];
        n_item.cksum_ok = i_data[164];
        n_item.iss      = i_data[196:165];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tcse_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcse_queue
// Two-entry queue between the decode front and the table back end.
// ----------------------------------------------------------------------------
module tcse_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  tcse_pkg::t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output tcse_pkg::t_item o_item
);
    import tcse_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tcse_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcse_back
// Connection table: port lookup, free-port search and read-modify-write
// of one entry per item, with a registered result.
// ----------------------------------------------------------------------------
module tcse_back #(
    parameter int ENTRIES = tcse_pkg::ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_valid,
    input  tcse_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output tcse_pkg::t_result o_result
);
    import tcse_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_back_state r_state, n_state;
    t_item       r_item;
    logic [15:0] r_port [ENTRIES];
    t_record     r_mem  [ENTRIES];
    t_record     r_rd;
    logic [15:0] r_init_win;
    logic [15:0] r_cand;
    logic        r_found, r_free_found;
    logic [IW-1:0] r_idx, r_free_idx;
    logic        r_out_valid;
    t_result     r_out;

    logic        look_found, look_free, cand_hit;
    logic [IW-1:0] look_idx, look_free_idx;
    logic        exec_go;
    t_result     res;
    t_record     nrec;
    logic        mem_we, port_we;
    logic [IW-1:0] waddr;
    logic [15:0] port_wd;
    t_kind       send;
    logic        drop;

    // lowest-index match and free entry
    always_comb begin
        look_found    = 1'b0;
        look_free     = 1'b0;
        look_idx      = '0;
        look_free_idx = '0;
        cand_hit      = 1'b0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (r_item.lport != 16'd0 && r_port[k] == r_item.lport) begin
                look_found = 1'b1;
                look_idx   = IW'(k);
            end
            if (r_port[k] == 16'd0) begin
                look_free     = 1'b1;
                look_free_idx = IW'(k);
            end
            if (r_port[k] == r_cand) begin
                cand_hit = 1'b1;
            end
        end
    end

    assign exec_go = (r_state == B_EXEC) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (i_valid) n_state = B_LOOK;
            B_LOOK: begin
                if (r_item.op == OP_LISTEN && r_item.lport == 16'd0) begin
                    n_state = B_SEARCH;
                end else begin
                    n_state = B_READ;
                end
            end
            B_SEARCH: if (!cand_hit) n_state = B_READ;
            B_READ:   n_state = B_EXEC;
            B_EXEC:   if (exec_go) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    assign o_pop = (r_state == B_IDLE) && i_valid;

    // execute one command on the entry that was read
    always_comb begin
        res     = '0;
        nrec    = r_rd;
        mem_we  = 1'b0;
        port_we = 1'b0;
        port_wd = 16'd0;
        waddr   = r_idx;
        send    = K_NONE;
        drop    = 1'b0;
        case (r_item.op)
            OP_SEG: begin
                if (!r_item.cksum_ok) begin
                    res.code = RC_BADSUM;
                end else if (!r_found) begin
                    res.code  = RC_NOPORT;
                    res.kind  = K_RST;
                    res.seq   = r_item.ack;
                    res.ack   = r_item.seq + 32'd1;
                    res.sport = r_item.lport;
                    res.dport = r_item.rport;
                    res.ip    = r_item.rip;
                end else if (r_rd.rcv_next != 32'd0 && r_item.seq != r_rd.rcv_next) begin
                    res.code  = RC_OOS;
                    res.slot  = 4'(r_idx);
                    res.state = r_rd.state;
                end else begin
                    mem_we = 1'b1;
                    if (r_item.flags[3] && (r_rd.state inside {ST_SYN_SENT, ST_SYN_RECV,
                            ST_ESTAB, ST_FW1, ST_FW2, ST_CLOSING, ST_CLOSE_WAIT})) begin
                        nrec.rcv_next = r_item.seq;
                        nrec.snd_una  = r_item.ack;
                        drop          = 1'b1;
                    end else begin
                        case (r_rd.state)
                            ST_SYN_SENT: if (r_item.flags[0]) begin
                                nrec.state    = r_item.flags[1] ? ST_ESTAB : ST_SYN_RECV;
                                nrec.rcv_next = r_item.seq + 32'd1;
                                nrec.snd_una  = r_item.ack;
                                send          = K_ACK;
                            end
                            ST_SYN_RECV: if (r_item.flags[1]) begin
                                nrec.state    = ST_ESTAB;
                                nrec.rcv_next = r_item.seq;
                                nrec.snd_una  = r_item.ack;
                            end
                            ST_LISTEN: if (r_item.flags[0]) begin
                                nrec.state     = ST_SYN_RECV;
                                nrec.peer_ip   = r_item.rip;
                                nrec.peer_port = r_item.rport;
                                nrec.rcv_next  = r_item.seq + 32'd1;
                                send           = K_SYNACK;
                            end
                            ST_FW1: begin
                                if (r_item.flags[2]) begin
                                    nrec.state    = r_item.flags[1] ? ST_TIME_WAIT : ST_CLOSING;
                                    nrec.rcv_next = r_item.seq + 32'(r_item.len) + 32'd1;
                                    nrec.snd_una  = r_item.ack;
                                    send          = K_ACK;
                                end else if (r_item.flags[1]) begin
                                    nrec.state    = ST_FW2;
                                    nrec.rcv_next = r_item.seq;
                                    nrec.snd_una  = r_item.ack;
                                end
                            end
                            ST_FW2: if (r_item.flags[2]) begin
                                nrec.state    = ST_TIME_WAIT;
                                nrec.rcv_next = r_item.seq + 32'(r_item.len) + 32'd1;
                                nrec.snd_una  = r_item.ack;
                                send          = K_ACK;
                            end
                            ST_CLOSING: if (r_item.flags[1]) begin
                                nrec.state    = ST_TIME_WAIT;
                                nrec.rcv_next = r_item.seq;
                                nrec.snd_una  = r_item.ack;
                            end
                            ST_CLOSE_WAIT: if (r_item.flags[1]) begin
                                nrec.rcv_next = r_item.seq;
                                nrec.snd_una  = r_item.ack;
                                drop          = 1'b1;
                            end
                            ST_ESTAB: begin
                                nrec.snd_una = r_item.ack;
                                if (r_item.flags[2]) begin
                                    nrec.state    = ST_CLOSE_WAIT;
                                    nrec.rcv_next = r_item.seq + 32'(r_item.len) + 32'd1;
                                    send          = K_FIN;
                                end else begin
                                    nrec.rcv_next = r_item.seq + 32'(r_item.len);
                                    if (r_item.len != 16'd0) send = K_ACK;
                                end
                            end
                            default: ;
                        endcase
                    end
                    res.slot = 4'(r_idx);
                end
            end
            OP_LISTEN, OP_CONNECT: begin
                if (r_found || (r_item.op == OP_CONNECT && r_item.lport == 16'd0)) begin
                    res.code = RC_EXISTS;
                end else if (!r_free_found) begin
                    res.code = RC_FULL;
                end else begin
                    mem_we         = 1'b1;
                    port_we        = 1'b1;
                    port_wd        = r_item.lport;
                    waddr          = r_free_idx;
                    nrec.snd_una   = r_item.iss;
                    nrec.snd_win   = r_init_win;
                    nrec.rcv_next  = 32'd0;
                    res.slot       = 4'(r_free_idx);
                    if (r_item.op == OP_LISTEN) begin
                        nrec.peer_port = 16'd0;
                        nrec.peer_ip   = 32'd0;
                        nrec.state     = ST_LISTEN;
                    end else begin
                        nrec.peer_port = r_item.rport;
                        nrec.peer_ip   = r_item.rip;
                        nrec.state     = ST_SYN_SENT;
                        send           = K_SYN;
                    end
                end
            end
            OP_CLOSE, OP_ABORT: begin
                if (!r_found) begin
                    res.code = RC_NOPORT;
                end else begin
                    mem_we   = 1'b1;
                    res.slot = 4'(r_idx);
                    if (r_item.op == OP_ABORT) begin
                        send = K_RST;
                        drop = 1'b1;
                    end else if (r_rd.state == ST_ESTAB) begin
                        nrec.state = ST_FW1;
                        send       = K_FIN;
                    end else begin
                        drop = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (drop) begin
            nrec.state = ST_CLOSE;
            port_we    = 1'b1;
            port_wd    = 16'd0;
        end
        if (mem_we) begin
            res.state = nrec.state;
        end
        if (send != K_NONE) begin
            res.kind  = send;
            res.seq   = nrec.snd_una;
            res.ack   = nrec.rcv_next;
            res.sport = r_item.lport;
            res.dport = nrec.peer_port;
            res.ip    = nrec.peer_ip;
            res.win   = nrec.snd_win;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_init_win  <= WIN_RST_DEF;
            for (int k = 0; k < ENTRIES; k++) begin
                r_port[k] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_init_win <= i_cfg_wdata;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec_go && port_we) begin
                r_port[waddr] <= port_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == B_LOOK) begin
            r_found      <= look_found;
            r_idx        <= look_idx;
            r_free_found <= look_free;
            r_free_idx   <= look_free_idx;
            r_cand       <= PORT_FIRST;
        end
        // advance the candidate until a port not in the table turns up
        if (r_state == B_SEARCH) begin
            if (cand_hit) begin
                r_cand <= r_cand + 16'd1;
            end else begin
                r_item.lport <= r_cand;
            end
        end
        if (exec_go) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_READ) begin
            r_rd <= r_mem[r_idx];
        end
        if (exec_go && mem_we) begin
            r_mem[waddr] <= nrec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tcp_connection_state_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_connection_state_engine_core
// TCP connection table and state machine, one result item per command item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tuser is the command, tdata the segment
//   header fields and the initial send sequence. m_axis returns one result
//   item per command naming the segment to send. i_cfg_we / i_cfg_wdata set
//   the window given to new connections; write it only while idle.
//   A front stage registers and decodes each item into a two-entry queue;
//   the back end handles one item at a time: pop, port lookup, entry read,
//   execute and write back. A listen on port 0 adds a search step that
//   probes ports from 32768 upward until one not in the table turns up.
//   The back end takes no new item until the current one has been written
//   back to the entry memory.
//   Reset empties the table and sets the window to 65535. If the receiver
//   stalls, the result holds in m_axis; the queue keeps filling, then
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module tcp_connection_state_engine_core #(
    parameter int ENTRIES = tcse_pkg::ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [15:0]                     i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // local_port, remote_port, remote_ip, seq_num, ack_num, seg_flags,
    // peer_window, payload_len, checksum_ok, initial_seq
    input  wire logic [tcse_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [tcse_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // result_code, send_kind, out_seq, out_ack, out_src_port, out_dst_port,
    // out_dst_ip, out_window, slot, conn_state
    output logic [tcse_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import tcse_pkg::*;

    logic    f_valid, q_full, q_valid, q_pop;
    t_item   f_item, q_item;
    t_result res;

    tcse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    tcse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tcse_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (res)
    );

    assign m_axis_tdata = {2'b00, res};

endmodule
`default_nettype wire
